[src/double_ended_queue_defines.svh]
// Assertion helpers used by the deque RTL in dq_ctrl.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define DQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/dq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 3;

    // m_tdata layout
    localparam int OUT_W      = WORD_W + 1 + CNT_W + 1 + 1;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic             is_read;
        logic             found;
        logic [CNT_W-1:0] count;
        logic             is_empty;
        logic             overflow;
    } rsp_t;

endpackage

`default_nettype wire

[src/dq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[src/dq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_defines.svh"

module dq_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [dq_pkg::WORD_W-1:0]        s_tdata,  // data_in
    input  wire logic [dq_pkg::CMD_W-1:0]         s_tuser,  // cmd
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [dq_pkg::OUT_DATA_W-1:0]    m_tdata,
    output dq_pkg::ram_req_t                      ram_req,
    input  wire logic [dq_pkg::WORD_W-1:0]        ram_rdata
);

    import dq_pkg::*;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    rsp_t                rsp_reg, rsp_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic                in_fire;
    logic                out_free;
    logic                load_out;
    logic                full;
    logic                empty;
    logic [ADDR_W-1:0]   front_dec;
    logic [ADDR_W-1:0]   front_inc;
    logic [SUM_W-1:0]    tail_sum;
    logic [SUM_W-1:0]    last_sum;
    logic [ADDR_W-1:0]   tail_slot;
    logic [ADDR_W-1:0]   last_slot;
    logic [WORD_W-1:0]   rsp_value;

    assign in_fire  = s_tvalid & s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == ADDR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    // slot one past the back, and the back slot itself, wrapped into the ring
    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign last_sum  = tail_sum - 1'b1;
    assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
                                                   : ADDR_W'(tail_sum);
    assign last_slot = (last_sum >= SUM_W'(DEPTH)) ? ADDR_W'(last_sum - SUM_W'(DEPTH))
                                                   : ADDR_W'(last_sum);

    // command decode, pointer update and RAM access, all in the accept cycle
    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        ram_req.we       = 1'b0;
        ram_req.re       = 1'b0;
        ram_req.addr     = front_reg;
        ram_req.wdata    = s_tdata;
        rsp_next         = rsp_reg;
        if (in_fire)
        begin
            rsp_next.is_read  = 1'b0;
            rsp_next.found    = 1'b0;
            rsp_next.overflow = 1'b0;
            unique case (s_tuser)
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        rsp_next.overflow = 1'b1;
                    end
                    else
                    begin
                        front_next   = front_dec;
                        ram_req.we   = 1'b1;
                        ram_req.addr = front_dec;
                        count_next   = count_reg + 1'b1;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        rsp_next.overflow = 1'b1;
                    end
                    else
                    begin
                        ram_req.we   = 1'b1;
                        ram_req.addr = tail_slot;
                        count_next   = count_reg + 1'b1;
                    end
                end
                CMD_POP_FRONT, CMD_PEEK_FRONT:
                begin
                    rsp_next.is_read = 1'b1;
                    if (!empty)
                    begin
                        rsp_next.found = 1'b1;
                        ram_req.re     = 1'b1;
                        ram_req.addr   = front_reg;
                        if (s_tuser == CMD_POP_FRONT)
                        begin
                            front_next = front_inc;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                CMD_POP_BACK, CMD_PEEK_BACK:
                begin
                    rsp_next.is_read = 1'b1;
                    if (!empty)
                    begin
                        rsp_next.found = 1'b1;
                        ram_req.re     = 1'b1;
                        ram_req.addr   = last_slot;
                        if (s_tuser == CMD_POP_BACK)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            rsp_next.count    = count_next;
            rsp_next.is_empty = (count_next == '0);
        end
    end

    // read data stays in the RAM output register until the next read
    assign rsp_value = rsp_reg.found   ? ram_rdata :
                       rsp_reg.is_read ? {WORD_W{1'b1}} : '0;

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    s_tready = 1'b1;
                    if (!s_tvalid)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {rsp_reg.overflow, rsp_reg.is_empty, rsp_reg.count,
                              rsp_reg.found, rsp_value};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg      <= rsp_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

    `DQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "held count exceeds depth")
    `DQ_ASSERT(a_ram_on_accept, (ram_req.we || ram_req.re) |-> in_fire, "RAM access without a transaction")
    `DQ_ASSERT(a_resp_origin, (state_reg == ST_RESP) |-> ($past(in_fire) || $past(state_reg == ST_RESP)), "response state without a prior transaction")
    `DQ_ASSERT(a_overflow_full, (in_fire && rsp_next.overflow) |-> full, "push flagged as dropped with room left")
    `DQ_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !out_valid_reg, "result pending during reset")

endmodule

`default_nettype wire

[src/double_ended_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of 32-bit words in a 1024-entry single-port ring RAM.
// Each input transaction carries one command in s_tuser (push front, push back,
// pop front, pop back, peek front, peek back) and the word to push in s_tdata;
// each command returns exactly one result on the m_ side: the popped or peeked
// word (-1 with found clear when empty, 0 for pushes), the entry count and empty
// flag after the command, and an overflow flag for a push into a full queue,
// which is dropped. The pointer update and the RAM access happen in the accept
// cycle, the registered RAM read lands in the following one and the result then
// goes into the output register, so back-to-back commands are taken at one per
// cycle as long as the result side keeps taking them.
// The RAM content after reset is not cleared; only held entries are ever read.
module double_ended_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dq_pkg::WORD_W-1:0]     s_tdata,   // data_in[31:0]
    input  wire logic [dq_pkg::CMD_W-1:0]      s_tuser,   // cmd[2:0]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // value[31:0], found[32], count[43:33], is_empty[44], overflow[45], zero pad
    output logic      [dq_pkg::OUT_DATA_W-1:0] m_tdata
);

    import dq_pkg::*;

    ram_req_t          ram_req;
    logic [WORD_W-1:0] ram_rdata;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[tb/tb_double_ended_queue.sv]
`timescale 1ns / 1ps

module tb_double_ended_queue;

    import dq_pkg::*;

    // codes 6 and 7 have no name in the package; the deque treats them as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 10;
    localparam int          MIXED_ITEMS = 100;
    localparam logic [31:0] JUNK        = 32'hDEAD_BEEF;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              found;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic              overflow;
    } deque_reply_t;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [WORD_W-1:0] word;
        logic              typed;
        deque_reply_t      reply;
    } stim_row_t;

    localparam deque_reply_t NO_REPLY    = '0;
    localparam deque_reply_t EMPTY_MISS  = '{32'hFFFF_FFFF, 1'b0, 11'd0, 1'b1, 1'b0};
    localparam deque_reply_t EMPTY_NOP   = '{32'h0, 1'b0, 11'd0, 1'b1, 1'b0};
    localparam int           N_DIRECTED  = 22;

    // extremes, every command, empty pops/peeks, spare codes, front wrap at slot 0
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{CMD_POP_FRONT,  JUNK,         1'b1, EMPTY_MISS},
        '{CMD_POP_BACK,   JUNK,         1'b1, EMPTY_MISS},
        '{CMD_PEEK_FRONT, 32'h0,        1'b1, EMPTY_MISS},
        '{CMD_PEEK_BACK,  32'hFFFF_FFFF,1'b1, EMPTY_MISS},
        '{CMD_SPARE_6,    JUNK,         1'b1, EMPTY_NOP},
        '{CMD_SPARE_7,    32'hFFFF_FFFF,1'b1, EMPTY_NOP},
        '{CMD_PUSH_BACK,  32'h7FFF_FFFF,1'b1, '{32'h0, 1'b0, 11'd1, 1'b0, 1'b0}},
        '{CMD_PUSH_FRONT, 32'h8000_0000,1'b1, '{32'h0, 1'b0, 11'd2, 1'b0, 1'b0}},
        '{CMD_PUSH_BACK,  32'hFFFF_FFFF,1'b1, '{32'h0, 1'b0, 11'd3, 1'b0, 1'b0}},
        '{CMD_PUSH_FRONT, 32'h0,        1'b1, '{32'h0, 1'b0, 11'd4, 1'b0, 1'b0}},
        '{CMD_PEEK_FRONT, JUNK,         1'b0, NO_REPLY},
        '{CMD_PEEK_BACK,  JUNK,         1'b0, NO_REPLY},
        '{CMD_SPARE_7,    JUNK,         1'b0, NO_REPLY},
        '{CMD_POP_FRONT,  JUNK,         1'b0, NO_REPLY},
        '{CMD_POP_BACK,   32'h0,        1'b0, NO_REPLY},
        '{CMD_POP_FRONT,  JUNK,         1'b0, NO_REPLY},
        '{CMD_POP_BACK,   JUNK,         1'b0, NO_REPLY},
        '{CMD_POP_BACK,   JUNK,         1'b1, EMPTY_MISS},
        '{CMD_PUSH_FRONT, 32'h5555_5555,1'b0, NO_REPLY},
        '{CMD_PUSH_BACK,  32'hAAAA_AAAA,1'b0, NO_REPLY},
        '{CMD_PEEK_BACK,  JUNK,         1'b0, NO_REPLY},
        '{CMD_POP_FRONT,  JUNK,         1'b0, NO_REPLY}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // travel alongside the driven command so the acceptance monitor knows its origin
    logic                  drv_typed;
    deque_reply_t          drv_reply;

    logic [WORD_W-1:0]     shadow_ring [DEPTH];
    logic [ADDR_W-1:0]     shadow_front;
    logic [CNT_W-1:0]      shadow_held;
    deque_reply_t          awaited_replies [$];

    int                    plan_held;
    int                    error_count;
    int                    cycle_count;
    bit                    send_calm;
    bit                    take_calm;

    double_ended_queue i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic deque_reply_t deque_apply(logic [CMD_W-1:0] op, logic [WORD_W-1:0] word);
        deque_reply_t r;
        logic [ADDR_W-1:0] slot;
        r = '0;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_held >= CNT_W'(DEPTH))
                begin
                    r.overflow = 1'b1;
                end
                else if (op == CMD_PUSH_FRONT)
                begin
                    shadow_front = shadow_front - 1'b1;
                    shadow_ring[shadow_front] = word;
                    shadow_held = shadow_held + 1'b1;
                end
                else
                begin
                    slot = ADDR_W'(shadow_front + shadow_held);
                    shadow_ring[slot] = word;
                    shadow_held = shadow_held + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT, CMD_POP_BACK, CMD_PEEK_BACK:
            begin
                if (shadow_held == '0)
                begin
                    r.value = '1;
                end
                else
                begin
                    if (op == CMD_POP_FRONT || op == CMD_PEEK_FRONT)
                        slot = shadow_front;
                    else
                        slot = ADDR_W'(shadow_front + shadow_held - 1'b1);
                    r.value = shadow_ring[slot];
                    r.found = 1'b1;
                    if (op == CMD_POP_FRONT)
                        shadow_front = shadow_front + 1'b1;
                    if (op == CMD_POP_FRONT || op == CMD_POP_BACK)
                        shadow_held = shadow_held - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count    = shadow_held;
        r.is_empty = (shadow_held == '0);
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_op(int push_pct, int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        if (r < 97)
            return $urandom_range(0, 1) ? CMD_PEEK_FRONT : CMD_PEEK_BACK;
        return $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    endfunction

    task automatic send_command(logic [CMD_W-1:0] op, logic [WORD_W-1:0] word,
                                logic typed, deque_reply_t reply);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= word;
        drv_typed <= typed;
        drv_reply <= reply;
        // track occupancy at issue time to steer the fill phase
        if ((op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) && plan_held < DEPTH)
            plan_held++;
        else if ((op == CMD_POP_FRONT || op == CMD_POP_BACK) && plan_held > 0)
            plan_held--;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_random(int push_pct, int pop_pct);
        send_command(pick_op(push_pct, pop_pct), pick_word(), 1'b0, NO_REPLY);
    endtask

    // input acceptance: predict and queue what the deque owes for this transaction
    always @(posedge clk)
    begin
        deque_reply_t predicted;
        if (rst_n && s_tvalid && s_tready)
        begin
            predicted = deque_apply(s_tuser, s_tdata);
            awaited_replies.insert(awaited_replies.size(), drv_typed ? drv_reply : predicted);
        end
    end

    // output acceptance: compare against the oldest outstanding reply
    always @(posedge clk)
    begin
        deque_reply_t want;
        deque_reply_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.value    = m_tdata[31:0];
            got.found    = m_tdata[32];
            got.count    = m_tdata[43:33];
            got.is_empty = m_tdata[44];
            got.overflow = m_tdata[45];
            if (awaited_replies.size() == 0)
            begin
                $error("unexpected result transaction: value %0d count %0d",
                       $signed(got.value), got.count);
                error_count++;
            end
            else
            begin
                want = awaited_replies[0];
                awaited_replies.delete(0);
                if (got.value !== want.value)
                begin
                    $error("value mismatch: expected %0d, actual %0d",
                           $signed(want.value), $signed(got.value));
                    error_count++;
                end
                if (got.found !== want.found)
                begin
                    $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
                    error_count++;
                end
                if (got.count !== want.count)
                begin
                    $error("count mismatch: expected %0d, actual %0d", want.count, got.count);
                    error_count++;
                end
                if (got.is_empty !== want.is_empty)
                begin
                    $error("is_empty mismatch: expected %0d, actual %0d",
                           want.is_empty, got.is_empty);
                    error_count++;
                end
                if (got.overflow !== want.overflow)
                begin
                    $error("overflow mismatch: expected %0d, actual %0d",
                           want.overflow, got.overflow);
                    error_count++;
                end
            end
        end
    end

    // result side: random back-pressure per transaction, with calm stretches
    initial
    begin
        int stall;
        m_tready = 1'b0;
        take_calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        drv_typed    = 1'b0;
        drv_reply    = NO_REPLY;
        shadow_front = '0;
        shadow_held  = '0;
        plan_held    = 0;
        error_count  = 0;
        cycle_count  = 0;
        send_calm    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_command(DIRECTED[i].op, DIRECTED[i].word, DIRECTED[i].typed,
                         DIRECTED[i].reply);

        for (int i = 0; i < MIXED_ITEMS; i++)
            send_random(45, 30);

        // fill to the brim, then hammer pushes into the full ring
        while (plan_held < DEPTH)
            send_random(95, 0);
        for (int i = 0; i < 30; i++)
            send_random(80, 5);

        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
